FILE: rtl/stream_grouping_router_top_assert.svh
// Assertion macros shared by the router RTL.
`ifndef STREAM_GROUPING_ROUTER_TOP_ASSERT_SVH
`define STREAM_GROUPING_ROUTER_TOP_ASSERT_SVH

// Antecedent holds in a cycle, consequent must hold in the same cycle.
`define SGR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("router assertion failed");

// Antecedent holds in a cycle, consequent must hold in the next cycle.
`define SGR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("router assertion failed");

`endif

FILE: rtl/sgr_pkg.sv
`default_nettype none
package sgr_pkg;

  localparam int KeyW   = 64;
  localparam int CntW   = 7;
  localparam int IdxW   = 6;
  localparam int LoadW  = 32;
  localparam int Depth  = 64;
  localparam int DigitW = 8;

  localparam logic [2:0] MODE_SHUFFLE = 3'd0;
  localparam logic [2:0] MODE_KEY     = 3'd1;
  localparam logic [2:0] MODE_BCAST   = 3'd2;
  localparam logic [2:0] MODE_MCAST   = 3'd3;
  localparam logic [2:0] MODE_CHOICE  = 3'd4;

  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_WORKERS = 2'd1;
  localparam logic [1:0] REG_FANOUT  = 2'd2;

  localparam logic [CntW-1:0] CountMax = 7'd64;

  typedef logic [CntW-1:0] cnt_t;

  // Clamps a count register to 1..64.
  function automatic cnt_t clamp_count(cnt_t v);
    cnt_t r;
    r = v;
    if (v == '0) r = 7'd1;
    else if (v > CountMax) r = CountMax;
    return r;
  endfunction

  // Eight restoring remainder steps, most significant dividend bit first.
  function automatic cnt_t mod_step8(cnt_t rem, logic [DigitW-1:0] bits, cnt_t d);
    cnt_t t;
    t = rem;
    for (int k = DigitW - 1; k >= 0; k--) begin
      t = {t[CntW-2:0], bits[k]};
      if (t >= d) t = t - d;
    end
    return t;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/stream_grouping_router_top.sv
// One 64-bit remainder is a load followed by 8 digit steps of 8 bits each.
// Transactions are taken one at a time: in_stall stays high until the sequencer is idle again.
// Reset (rst_n low, synchronous): config to defaults, round-robin and all loads to zero.
`default_nettype none
`include "stream_grouping_router_top_assert.svh"
module stream_grouping_router_top
  import sgr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CntW-1:0]   cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [KeyW-1:0]   in_key_hash,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [IdxW-1:0]        out_slot,
  output logic [IdxW-1:0]        out_dest,
  output logic [IdxW-1:0]        out_tag,
  output logic                   out_last
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;  // remainder unit running
  localparam logic [2:0] S_POST = 3'd2;  // remainder ready, decide next step
  localparam logic [2:0] S_EMIT = 3'd3;  // hand one route to the output register
  localparam logic [2:0] S_CMP  = 3'd4;  // load word read back, compare
  localparam logic [2:0] S_WR   = 3'd5;  // bump winning load counter

  // Configuration registers.
  logic [2:0]      mode_r;
  cnt_t            wc_r, fc_r;
  cnt_t            n_eff, f_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SHUFFLE;
      wc_r   <= 7'd1;
      fc_r   <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:    mode_r <= cfg_data[2:0];
        REG_WORKERS: wc_r   <= cfg_data;
        REG_FANOUT:  fc_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign n_eff = clamp_count(wc_r);
  assign f_eff = clamp_count(fc_r);

  // Sequencer and datapath registers.
  logic [2:0]      state_r, state_nxt;
  logic [1:0]      ph_r, ph_nxt;         // multicast phase
  logic [KeyW-1:0] h_r, h_nxt;
  cnt_t            idx_r, idx_nxt;
  logic [IdxW-1:0] rr_r, rr_nxt;
  logic [IdxW-1:0] p_r, p_nxt;
  logic [IdxW-1:0] prim_r, prim_nxt;
  logic [IdxW-1:0] best_r, best_nxt;
  logic [LoadW-1:0] best_load_r, best_load_nxt;

  // Shared remainder unit: magnitude of a 64-bit value modulo a 7-bit count.
  logic [KeyW-1:0] mag_r, mag_nxt;
  cnt_t            rem_r, rem_nxt;
  cnt_t            mod_d_r, mod_d_nxt;
  logic [2:0]      mod_cnt_r, mod_cnt_nxt;

  // Load table: memory plus one valid flag per worker so reset clears it at once.
  logic [LoadW-1:0] load_mem [Depth];
  logic [LoadW-1:0] rd_data_r;
  logic [Depth-1:0] vld_r;
  logic             rd_vld_r;
  logic             mem_we;
  logic [LoadW-1:0] load_val;
  logic [LoadW-1:0] load_inc;

  // Output register.
  logic            out_valid_r;
  logic [IdxW-1:0] out_slot_r, out_dest_r, out_tag_r;
  logic            out_last_r;
  logic            out_free;
  logic            out_load;
  logic [IdxW-1:0] emit_slot, emit_dest, emit_tag;
  logic            emit_last;

  logic            in_acc;
  logic [KeyW-1:0] mod_x;
  logic            mod_start;
  cnt_t            mod_div;
  cnt_t            idx_inc;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign idx_inc  = idx_r + 7'd1;

  // A load word that was never written since reset reads as zero.
  assign load_val = rd_vld_r ? rd_data_r : '0;
  assign load_inc = (best_load_r == '1) ? best_load_r : best_load_r + 32'd1;

  // Payload of the route the sequencer is about to emit.
  always_comb begin
    emit_slot = '0;
    emit_dest = '0;
    emit_tag  = '0;
    emit_last = 1'b1;
    case (mode_r)
      MODE_SHUFFLE: emit_dest = rr_r;
      MODE_KEY:     emit_dest = rem_r[IdxW-1:0];
      MODE_BCAST: begin
        emit_slot = idx_r[IdxW-1:0];
        emit_dest = idx_r[IdxW-1:0];
        emit_tag  = prim_r;
        emit_last = (idx_inc == n_eff);
      end
      MODE_MCAST: begin
        emit_slot = idx_r[IdxW-1:0];
        emit_dest = (idx_r[IdxW-1:0] == p_r) ? prim_r : rem_r[IdxW-1:0];
        emit_tag  = p_r;
        emit_last = (idx_inc == f_eff);
      end
      MODE_CHOICE:  emit_dest = best_r;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    h_nxt         = h_r;
    idx_nxt       = idx_r;
    rr_nxt        = rr_r;
    p_nxt         = p_r;
    prim_nxt      = prim_r;
    best_nxt      = best_r;
    best_load_nxt = best_load_r;
    mod_start     = 1'b0;
    mod_x         = h_r;
    mod_div       = n_eff;
    out_load      = 1'b0;
    mem_we        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          h_nxt   = in_key_hash;
          idx_nxt = '0;
          ph_nxt  = 2'd0;
          mod_x   = in_key_hash;
          case (mode_r)
            MODE_SHUFFLE: begin
              mod_x     = {{(KeyW-CntW){1'b0}}, {1'b0, rr_r} + 7'd1};
              mod_start = 1'b1;
            end
            MODE_KEY, MODE_BCAST, MODE_CHOICE: mod_start = 1'b1;
            MODE_MCAST: begin
              mod_div   = f_eff;
              mod_start = 1'b1;
            end
            default: ;  // unused modes drop the transaction
          endcase
        end
      end

      S_MOD: begin
        if (mod_cnt_r == 3'd7) state_nxt = S_POST;
      end

      S_POST: begin
        case (mode_r)
          MODE_SHUFFLE: begin
            rr_nxt    = rem_r[IdxW-1:0];
            state_nxt = S_EMIT;
          end
          MODE_BCAST: begin
            prim_nxt  = rem_r[IdxW-1:0];
            state_nxt = S_EMIT;
          end
          MODE_MCAST: begin
            if (ph_r == 2'd0) begin
              p_nxt     = rem_r[IdxW-1:0];
              ph_nxt    = 2'd1;
              mod_start = 1'b1;
            end else if (ph_r == 2'd1) begin
              prim_nxt = rem_r[IdxW-1:0];
              ph_nxt   = 2'd2;
              if (p_r == '0) begin
                state_nxt = S_EMIT;
              end else begin
                mod_x     = h_r + {{(KeyW-IdxW){1'b0}}, p_r};
                mod_start = 1'b1;
              end
            end else begin
              state_nxt = S_EMIT;
            end
          end
          MODE_CHOICE: state_nxt = S_CMP;  // load word read issued this cycle
          default:     state_nxt = S_EMIT;
        endcase
      end

      S_CMP: begin
        if (idx_r == '0 || load_val < best_load_r) begin
          best_nxt      = rem_r[IdxW-1:0];
          best_load_nxt = load_val;
        end
        idx_nxt = idx_inc;
        if (idx_inc < f_eff) begin
          mod_x     = h_r + {{(KeyW-CntW){1'b0}}, idx_inc};
          mod_start = 1'b1;
        end else begin
          state_nxt = S_WR;
        end
      end

      S_WR: begin
        mem_we    = 1'b1;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (!emit_last && (mode_r == MODE_BCAST || mode_r == MODE_MCAST)) begin
            idx_nxt   = idx_inc;
            state_nxt = S_EMIT;
            if (mode_r == MODE_MCAST && idx_inc[IdxW-1:0] != p_r) begin
              mod_x     = h_r + {{(KeyW-IdxW){1'b0}}, p_r}
                              + {{(KeyW-CntW){1'b0}}, idx_inc};
              mod_start = 1'b1;
            end
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (mod_start) state_nxt = S_MOD;
  end

  // Remainder unit datapath.
  always_comb begin
    mag_nxt     = mag_r;
    rem_nxt     = rem_r;
    mod_d_nxt   = mod_d_r;
    mod_cnt_nxt = mod_cnt_r;
    if (mod_start) begin
      mag_nxt     = mod_x[KeyW-1] ? (~mod_x + 64'd1) : mod_x;
      rem_nxt     = '0;
      mod_d_nxt   = mod_div;
      mod_cnt_nxt = '0;
    end else if (state_r == S_MOD) begin
      rem_nxt     = mod_step8(rem_r, mag_r[KeyW-1 -: DigitW], mod_d_r);
      mag_nxt     = {mag_r[KeyW-DigitW-1:0], {DigitW{1'b0}}};
      mod_cnt_nxt = mod_cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= 2'd0;
      rr_r        <= '0;
      mod_cnt_r   <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ph_r      <= ph_nxt;
      rr_r      <= rr_nxt;
      mod_cnt_r <= mod_cnt_nxt;
      if (mem_we) vld_r[best_r] <= 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    h_r         <= h_nxt;
    idx_r       <= idx_nxt;
    p_r         <= p_nxt;
    prim_r      <= prim_nxt;
    best_r      <= best_nxt;
    best_load_r <= best_load_nxt;
    mag_r       <= mag_nxt;
    rem_r       <= rem_nxt;
    mod_d_r     <= mod_d_nxt;
    rd_vld_r    <= vld_r[rem_r[IdxW-1:0]];
    if (out_load) begin
      out_slot_r <= emit_slot;
      out_dest_r <= emit_dest;
      out_tag_r  <= emit_tag;
      out_last_r <= emit_last;
    end
  end

  // Load memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) load_mem[best_r] <= load_inc;
    rd_data_r <= load_mem[rem_r[IdxW-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_slot  = out_slot_r;
  assign out_dest  = out_dest_r;
  assign out_tag   = out_tag_r;
  assign out_last  = out_last_r;

  // The remainder unit never runs with a zero divisor.
  `SGR_ASSERT_SAME(a_mod_div_nonzero, state_r == S_MOD, mod_d_r != '0)
  // A candidate worker is always below the worker count.
  `SGR_ASSERT_SAME(a_cand_range, state_r == S_CMP, rem_r < n_eff)
  // Broadcast never walks past the last worker.
  `SGR_ASSERT_SAME(a_bcast_range, state_r == S_EMIT && mode_r == MODE_BCAST, idx_r < n_eff)
  // A load update is always followed by the route that reports it.
  `SGR_ASSERT_NEXT(a_wr_then_emit, state_r == S_WR, state_r == S_EMIT)

endmodule
`default_nettype wire
